### hdl/pfba_pkg.sv
package pfba_pkg;

	localparam int unsigned BITMAP_BYTES_DEF = 4096;
	localparam int unsigned PAGE_SHIFT_DEF   = 12;

	// request selector
	localparam logic [1:0] FN_INIT  = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_ALLOC = 2'd2;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FRAME = 2'd1;
	localparam logic [1:0] ST_BEYOND   = 2'd2;

	// register map, indexed by paddr[2]
	localparam int unsigned PADDR_W    = 3;
	localparam logic        REG_KSTART = 1'b0;
	localparam logic        REG_KCOUNT = 1'b1;

	localparam logic [31:0] KSTART_RESET = 32'h0010_0000;
	localparam logic [15:0] KCOUNT_RESET = 16'h0000;

	typedef struct packed {
		logic [31:0] kernel_start_address;
		logic [15:0] kernel_frame_count;
	} cfg_t;

	function automatic int unsigned num_words(input int unsigned bytes);
		return (bytes * 8 + 31) / 32;
	endfunction

	function automatic int unsigned word_aw(input int unsigned bytes);
		return (num_words(bytes) > 1) ? $clog2(num_words(bytes)) : 1;
	endfunction

endpackage

### hdl/pfba_if.sv
interface pfba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] phys_addr;

	modport source (output valid, output func, output phys_addr, input ready);
	modport sink   (input valid, input func, input phys_addr, output ready);
endinterface

interface pfba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_address;
	logic [1:0]  status;

	modport source (output valid, output frame_address, output status, input ready);
	modport sink   (input valid, input frame_address, input status, output ready);
endinterface

### hdl/page_frame_bitmap_allocator.sv
// First-fit page frame allocator: one used bit per 2^PAGE_SHIFT-byte frame, held as
// 32-bit words in a single-port-read, single-port-write RAM of BITMAP_BYTES/4 words
// (1024 by default). After reset the block clears the RAM one word per cycle and holds
// req.ready low until the clear is done; APB writes are taken meanwhile. Requests are
// served one at a time; each gives exactly one response beat, in order, and a new
// request is taken while the previous response still waits on rsp. Init rewrites every
// word, one per cycle. Free is a read-modify-write of one word, a read state and then a
// write state. Allocate streams words from word 0 through the RAM read port, one per
// cycle, and stops at the first word with a clear bit, or after the last word when the
// bitmap is full. A free beyond the bitmap or an unused selector goes straight to the
// response state. Configure kernel_start_address (0x0) and
// kernel_frame_count (0x4) only while no request is in flight.
module page_frame_bitmap_allocator #(
	parameter int unsigned BITMAP_BYTES = pfba_pkg::BITMAP_BYTES_DEF,
	parameter int unsigned PAGE_SHIFT   = pfba_pkg::PAGE_SHIFT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pfba_req_if.sink                     req,
	pfba_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfba_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import pfba_pkg::*;

	localparam int unsigned NUM_WORDS = num_words(BITMAP_BYTES);
	localparam int unsigned WORD_AW   = word_aw(BITMAP_BYTES);

	cfg_t               cfg;
	logic               mem_rd_en;
	logic [WORD_AW-1:0] mem_rd_addr;
	logic [31:0]        mem_rd_data;
	logic               mem_wr_en;
	logic [WORD_AW-1:0] mem_wr_addr;
	logic [31:0]        mem_wr_data;

	pfba_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfba_bitmap_mem #(
		.DEPTH (NUM_WORDS),
		.AW    (WORD_AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	pfba_ctrl #(
		.BITMAP_BYTES (BITMAP_BYTES),
		.PAGE_SHIFT   (PAGE_SHIFT),
		.WORD_AW      (WORD_AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req         (req),
		.rsp         (rsp),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

endmodule

### hdl/pfba_regs.sv
module pfba_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfba_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output pfba_pkg::cfg_t               cfg
);
	import pfba_pkg::*;

	cfg_t cfg_q;
	logic wr_beat;
	logic reg_sel;

	assign pready  = 1'b1;
	assign wr_beat = psel & penable & pwrite;
	assign reg_sel = paddr[2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_start_address <= KSTART_RESET;
			cfg_q.kernel_frame_count   <= KCOUNT_RESET;
		end else if (wr_beat) begin
			case (reg_sel)
				REG_KSTART: cfg_q.kernel_start_address <= pwdata;
				REG_KCOUNT: cfg_q.kernel_frame_count   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_KSTART: prdata = cfg_q.kernel_start_address;
			REG_KCOUNT: prdata = {16'd0, cfg_q.kernel_frame_count};
			default:    prdata = '0;
		endcase
	end

endmodule

### hdl/pfba_bitmap_mem.sv
module pfba_bitmap_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);

	logic [31:0] bitmap_q [DEPTH];
	logic [31:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			bitmap_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= bitmap_q[rd_addr];
	end

endmodule

### hdl/pfba_ctrl.sv
module pfba_ctrl #(
	parameter int unsigned BITMAP_BYTES = pfba_pkg::BITMAP_BYTES_DEF,
	parameter int unsigned PAGE_SHIFT   = pfba_pkg::PAGE_SHIFT_DEF,
	parameter int unsigned WORD_AW      = pfba_pkg::word_aw(BITMAP_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfba_pkg::cfg_t     cfg,
	pfba_req_if.sink           req,
	pfba_rsp_if.source         rsp,
	output logic               mem_rd_en,
	output logic [WORD_AW-1:0] mem_rd_addr,
	input  logic [31:0]        mem_rd_data,
	output logic               mem_wr_en,
	output logic [WORD_AW-1:0] mem_wr_addr,
	output logic [31:0]        mem_wr_data
);
	import pfba_pkg::*;

	localparam int unsigned NUM_FRAMES = BITMAP_BYTES * 8;
	localparam int unsigned NUM_WORDS  = num_words(BITMAP_BYTES);
	localparam int unsigned LAST_BITS  = NUM_FRAMES - 32 * (NUM_WORDS - 1);
	localparam logic [31:0] LAST_MASK  =
		(LAST_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LAST_BITS) - 64'd1);
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
	localparam int unsigned START_W = 32 - PAGE_SHIFT;
	localparam int unsigned FN_W    = WORD_AW + 5;
	localparam int unsigned CW      = ((START_W > FN_W) ? START_W : FN_W) + 2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_FREE_RD,
		S_FREE_WR,
		S_SCAN,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [WORD_AW-1:0] idx_q;
	logic               iss_more_q;
	logic [4:0]         bit_q;
	logic [WORD_AW-1:0] idx_s1;
	logic               chk_vld_s1;
	logic [31:0]        res_addr_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;
	logic [31:0]        out_addr_q;
	logic [1:0]         out_status_q;

	// ones in bit positions below n, n in 0..32
	function automatic logic [31:0] ones_below(input logic [5:0] n);
		return n[5] ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
	endfunction

	function automatic logic [31:0] word_mask(input logic [WORD_AW-1:0] w);
		return (w == LAST_WORD) ? LAST_MASK : 32'hFFFF_FFFF;
	endfunction

	// init mask for the word under sweep
	logic [CW-1:0] base, kstart, kend, d_lo, d_hi;
	logic [5:0]    lo, hi;
	logic [31:0]   init_mask;

	always_comb begin
		base   = CW'({idx_q, 5'd0});
		kstart = CW'(cfg.kernel_start_address >> PAGE_SHIFT);
		kend   = kstart + CW'(cfg.kernel_frame_count);
		d_lo   = kstart - base;
		d_hi   = kend - base;
		if (kstart <= base)
			lo = 6'd0;
		else if (d_lo >= CW'(32))
			lo = 6'd32;
		else
			lo = {1'b0, d_lo[4:0]};
		if (kend <= base)
			hi = 6'd0;
		else if (d_hi >= CW'(32))
			hi = 6'd32;
		else
			hi = {1'b0, d_hi[4:0]};
		init_mask = ones_below(hi) & ~ones_below(lo) & word_mask(idx_q);
	end

	// first-fit search on the word just read; padding bits count as used
	logic [31:0]     used;
	logic            has_free;
	logic [4:0]      free_bit;
	logic [FN_W-1:0] fnum;
	logic [31:0]     alloc_addr;

	always_comb begin
		used     = mem_rd_data | ~word_mask(idx_s1);
		has_free = ~&used;
		free_bit = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (!used[i])
				free_bit = 5'(i);
		end
		fnum       = {idx_s1, free_bit};
		alloc_addr = 32'(fnum) << PAGE_SHIFT;
	end

	// free request decode
	logic [31:0] fr_full;
	logic        fr_beyond;

	assign fr_full   = req.phys_addr >> PAGE_SHIFT;
	assign fr_beyond = fr_full >= 32'(NUM_FRAMES);

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			S_INIT: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = init_mask;
			end
			S_FREE_RD: begin
				mem_rd_en = 1'b1;
			end
			S_FREE_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = mem_rd_data & ~(32'd1 << bit_q);
			end
			S_SCAN: begin
				mem_rd_en = iss_more_q;
				if (chk_vld_s1 && has_free) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = idx_s1;
					mem_wr_data = mem_rd_data | (32'd1 << free_bit);
				end
			end
			default: ;
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.frame_address = out_addr_q;
	assign rsp.status        = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			iss_more_q  <= 1'b0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= mem_rd_en;
			idx_s1     <= idx_q;
			// in S_DONE the output register is reloaded below instead
			if (out_valid_q && rsp.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (idx_q == LAST_WORD) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + WORD_AW'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						res_addr_q <= '0;
						case (req.func)
							FN_INIT: begin
								res_status_q <= ST_OK;
								idx_q        <= '0;
								state_q      <= S_INIT;
							end
							FN_FREE: begin
								if (fr_beyond) begin
									res_status_q <= ST_BEYOND;
									idx_q        <= '0;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									idx_q        <= fr_full[FN_W-1:5];
									bit_q        <= fr_full[4:0];
									state_q      <= S_FREE_RD;
								end
							end
							FN_ALLOC: begin
								res_status_q <= ST_OK;
								idx_q        <= '0;
								iss_more_q   <= 1'b1;
								state_q      <= S_SCAN;
							end
							default: begin
								res_status_q <= ST_OK;
								idx_q        <= '0;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_INIT: begin
					idx_q <= idx_q + WORD_AW'(1);
					if (idx_q == LAST_WORD)
						state_q <= S_DONE;
				end
				S_FREE_RD: state_q <= S_FREE_WR;
				S_FREE_WR: state_q <= S_DONE;
				S_SCAN: begin
					if (iss_more_q)
						idx_q <= idx_q + WORD_AW'(1);
					if (chk_vld_s1 && (has_free || idx_s1 == LAST_WORD)) begin
						if (has_free)
							res_addr_q <= alloc_addr;
						else
							res_status_q <= ST_NO_FRAME;
						iss_more_q <= 1'b0;
						state_q    <= S_DONE;
					end else if (iss_more_q && idx_q == LAST_WORD) begin
						iss_more_q <= 1'b0;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/pfba_checker.sv
module pfba_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_func,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_addr,
	input logic [1:0]  out_status
);
	import pfba_pkg::*;

	// selectors of requests awaiting their response beat, oldest in f0_q
	logic [1:0] f0_q, f1_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push = in_valid & in_ready;
	assign pop  = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && pop) begin
				if (cnt_q == 2'd1) begin
					f0_q <= in_func;
				end else begin
					f0_q <= f1_q;
					f1_q <= in_func;
				end
			end else if (push) begin
				if (cnt_q == 2'd0)
					f0_q <= in_func;
				else
					f1_q <= in_func;
				cnt_q <= cnt_q + 2'd1;
			end else if (pop) begin
				f0_q  <= f1_q;
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_addr) && $stable(out_status))
		else $error("response beat changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_addr == 32'd0)
		else $error("failed response carries a frame address");

	a_free_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cnt_q != 2'd0 && f0_q == FN_FREE |->
			out_addr == 32'd0 && out_status != ST_NO_FRAME)
		else $error("free answered like an allocate");

	a_alloc_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cnt_q != 2'd0 && f0_q == FN_ALLOC |-> out_status != ST_BEYOND)
		else $error("allocate answered with address-beyond status");

endmodule

bind page_frame_bitmap_allocator pfba_props u_pfba_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.in_func    (req.func),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_addr   (rsp.frame_address),
	.out_status (rsp.status)
);

### bench/pfba_checker.sv
`timescale 1ns / 100ps

module pfba_checker
	import pfba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pfba_req_if                req,
	pfba_rsp_if                rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 replies_done,
	output int                 mismatches
);

	localparam int unsigned FRAMES = BITMAP_BYTES_DEF * 8;
	localparam int unsigned WORDS  = (FRAMES + 31) / 32;

	typedef struct packed {
		logic [31:0] frame_address;
		logic [1:0]  status;
	} reply_t;

	logic [31:0] frame_used [WORDS];
	cfg_t        kernel_cfg;
	reply_t      owed_replies [$];

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// kernel frames beyond the bitmap simply fall off the end
	task automatic lay_out_kernel();
		longint unsigned first;
		longint unsigned last;
		first = 64'(kernel_cfg.kernel_start_address >> PAGE_SHIFT_DEF);
		last  = first + 64'(kernel_cfg.kernel_frame_count);
		for (int unsigned f = 0; f < FRAMES; f++)
			frame_used[f / 32][f % 32] = (f >= first) && (f < last);
	endtask

	task automatic serve_frame_request(input logic [1:0] fn, input logic [31:0] pa,
			output reply_t r);
		int unsigned frame;
		bit          found;
		r.frame_address = '0;
		r.status        = ST_OK;
		found           = 1'b0;
		case (fn)
			FN_INIT: lay_out_kernel();
			FN_FREE: begin
				frame = pa >> PAGE_SHIFT_DEF;
				if (frame >= FRAMES)
					r.status = ST_BEYOND;
				else
					frame_used[frame / 32][frame % 32] = 1'b0;
			end
			FN_ALLOC: begin
				// first fit: lowest word with room, then lowest clear bit in it
				for (int unsigned w = 0; w < WORDS && !found; w++) begin
					if (frame_used[w] != '1) begin
						for (int unsigned b = 0; b < 32 && !found; b++) begin
							if (!frame_used[w][b]) begin
								frame_used[w][b] = 1'b1;
								frame            = w * 32 + b;
								r.frame_address  = frame << PAGE_SHIFT_DEF;
								found            = 1'b1;
							end
						end
					end
				end
				if (!found)
					r.status = ST_NO_FRAME;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t fresh;
		reply_t owed;
		if (!arst_n) begin
			foreach (frame_used[w])
				frame_used[w] = '0;
			kernel_cfg.kernel_start_address = KSTART_RESET;
			kernel_cfg.kernel_frame_count   = KCOUNT_RESET;
			owed_replies.delete();
			replies_done <= 0;
			mismatches   = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_KSTART)
					kernel_cfg.kernel_start_address = pwdata;
				else
					kernel_cfg.kernel_frame_count = pwdata[15:0];
			end
			if (rsp.valid && rsp.ready) begin
				replies_done <= replies_done + 1;
				if (owed_replies.size() == 0) begin
					flag_mismatch($sformatf("reply beat addr %h status %0d with nothing owed",
						rsp.frame_address, rsp.status));
				end else begin
					owed = owed_replies.pop_front();
					if (rsp.frame_address !== owed.frame_address)
						flag_mismatch($sformatf("frame_address %h, want %h",
							rsp.frame_address, owed.frame_address));
					if (rsp.status !== owed.status)
						flag_mismatch($sformatf("status %0d, want %0d (addr %h)",
							rsp.status, owed.status, owed.frame_address));
				end
			end
			if (req.valid && req.ready) begin
				serve_frame_request(req.func, req.phys_addr, fresh);
				owed_replies.push_back(fresh);
			end
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pfba_pkg::*;

	localparam int unsigned LIMIT     = 3_000_000;
	localparam logic [1:0]  FN_UNUSED = 2'd3;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	pfba_req_if req ();
	pfba_rsp_if rsp ();

	int replies_done;
	int mismatches;
	int sent;
	int cycles;
	int n_init, n_free, n_alloc, n_unused, layouts;
	bit steady;
	bit choke_rsp;

	always #5 clk = ~clk;

	page_frame_bitmap_allocator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pfba_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.replies_done (replies_done),
		.mismatches   (mismatches)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// response side: random back-pressure, or a long hold-off on request
	initial begin
		bit choke_done;
		choke_done = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (choke_rsp && !choke_done) begin
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				choke_done = 1'b1;
			end else begin
				rsp.ready <= steady || ($urandom_range(99) >= 29);
			end
		end
	end

	// called at a clock edge; returns at the edge that accepts the beat
	task automatic offer_request(input logic [1:0] fn, input logic [31:0] pa);
		while (!steady && $urandom_range(99) < 29) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.func      <= fn;
		req.phys_addr <= pa;
		do @(posedge clk); while (!req.ready);
		sent++;
		case (fn)
			FN_INIT:  n_init++;
			FN_FREE:  n_free++;
			FN_ALLOC: n_alloc++;
			default:  n_unused++;
		endcase
	endtask

	task automatic drain_replies();
		req.valid <= 1'b0;
		while (replies_done != sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic place_kernel(input logic [31:0] start, input logic [15:0] count);
		write_reg(REG_KSTART, start);
		write_reg(REG_KCOUNT, {16'h0, count});
		layouts++;
	endtask

	initial begin
		logic [31:0] start;
		logic [15:0] count;
		int unsigned pick;
		int unsigned roll;
		int unsigned frame;
		int unsigned taken;

		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		req.valid     <= 1'b0;
		req.func      <= FN_INIT;
		req.phys_addr <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bitmap is clear out of reset: frame zero comes back as address 0, status ok
		offer_request(FN_ALLOC, 32'hFFFF_FFFF);
		offer_request(FN_ALLOC, 32'h0000_0000);
		offer_request(FN_UNUSED, 32'hFFFF_FFFF);
		offer_request(FN_FREE, 32'h0000_0FFF);
		offer_request(FN_FREE, 32'h0000_0123);
		offer_request(FN_FREE, 32'h0800_0000);
		offer_request(FN_FREE, 32'hFFFF_FFFF);
		offer_request(FN_FREE, 32'h07FF_FFFF);
		offer_request(FN_ALLOC, 32'h5555_5555);

		// kernel starts mid-word and spans a count that is not a multiple of 32
		drain_replies();
		place_kernel(32'h0000_5123, 16'd70);
		offer_request(FN_INIT, 32'hAAAA_AAAA);
		offer_request(FN_ALLOC, 32'h0);
		offer_request(FN_ALLOC, 32'h0);
		offer_request(FN_FREE, 32'h0000_6000);
		repeat (4) offer_request(FN_ALLOC, 32'h0);

		// every frame taken by the kernel
		drain_replies();
		place_kernel(32'h0000_0000, 16'h8000);
		offer_request(FN_INIT, 32'h0);
		offer_request(FN_ALLOC, 32'h0);
		offer_request(FN_FREE, 32'h07FF_F000);
		offer_request(FN_ALLOC, 32'h0);
		offer_request(FN_ALLOC, 32'h0);

		// kernel wholly past the bitmap
		drain_replies();
		place_kernel(32'hFFFF_FFFF, 16'hFFFF);
		offer_request(FN_INIT, 32'h0);
		offer_request(FN_ALLOC, 32'h0);

		for (int ph = 0; ph < 9; ph++) begin
			drain_replies();
			pick = $urandom_range(9);
			if (pick < 6)
				start = ($urandom_range(32767) << PAGE_SHIFT_DEF) | $urandom_range(4095);
			else if (pick < 8)
				start = $urandom();
			else
				start = ((32768 - $urandom_range(1, 64)) << PAGE_SHIFT_DEF)
					| $urandom_range(4095);
			pick = $urandom_range(9);
			if (pick < 5)
				count = 16'($urandom_range(100));
			else if (pick < 8)
				count = 16'($urandom_range(32768));
			else if (pick < 9)
				count = 16'h8000;
			else
				count = 16'($urandom());
			place_kernel(start, count);
			steady = (ph == 3);
			offer_request(FN_INIT, $urandom());
			if (ph == 5)
				choke_rsp = 1'b1;
			taken = 0;
			for (int i = 0; i < 62; i++) begin
				roll = $urandom_range(99);
				if (roll < 46) begin
					offer_request(FN_ALLOC, $urandom());
					taken++;
				end else if (roll < 76) begin
					// hand back something likely in use: low frames or the kernel's
					frame = $urandom_range(taken + 8);
					if ($urandom_range(1))
						frame += start >> PAGE_SHIFT_DEF;
					offer_request(FN_FREE, (frame << PAGE_SHIFT_DEF) | $urandom_range(4095));
				end else if (roll < 84) begin
					offer_request(FN_FREE, $urandom());
				end else if (roll < 90) begin
					offer_request(FN_FREE, 32'h07FF_F000 + $urandom_range(32'h1FFF));
				end else if (roll < 95) begin
					offer_request(FN_UNUSED, $urandom());
				end else begin
					offer_request(FN_INIT, $urandom());
					taken = 0;
				end
			end
		end

		drain_replies();
		steady = 1'b0;
		repeat (40) @(posedge clk);
		$display("%0d requests: %0d allocate, %0d free, %0d init, %0d unused selector",
			sent, n_alloc, n_free, n_init, n_unused);
		$display("%0d kernel layouts incl. full and empty bitmaps, %0d cycles",
			layouts, cycles);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
